// File: hdl/rtnh_pkg.sv
// shared types, codes and the multiply-accumulate program of the ray/triangle engine
package rtnh_pkg;

  localparam int unsigned OPW = 34;   // multiplier operand width
  localparam int unsigned PRW = 68;   // product width
  localparam int unsigned ACW = 104;  // accumulator width
  localparam int unsigned CRW = 67;   // cross product component width
  localparam int unsigned DVW = 136;  // divider datapath width
  localparam int unsigned QW  = 32;   // quotient width
  localparam int unsigned NSTEP = 36;
  localparam int unsigned TSAT_SHIFT = 31;

  typedef struct packed {
    logic        mode;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] c_x;
    logic [31:0] c_y;
    logic [31:0] c_z;
    logic        last_tri;
  } in_t;

  typedef struct packed {
    logic        hit_found;
    logic [31:0] hit_distance;
    logic [16:0] bary_u;
    logic [16:0] bary_v;
    logic [15:0] hit_triangle;
  } out_t;

  typedef enum logic [3:0] {
    REG_ORIGIN_X = 4'd0,
    REG_ORIGIN_Y = 4'd1,
    REG_ORIGIN_Z = 4'd2,
    REG_DIR_X    = 4'd3,
    REG_DIR_Y    = 4'd4,
    REG_DIR_Z    = 4'd5,
    REG_DIST_MIN = 4'd6,
    REG_DIST_MAX = 4'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_D0, S_D1, S_D2,
    S_E10, S_E11, S_E12,
    S_E20, S_E21, S_E22,
    S_T0, S_T1, S_T2,
    S_PL0, S_PL1, S_PL2,
    S_PH0, S_PH1, S_PH2,
    S_QL0, S_QL1, S_QL2,
    S_QH0, S_QH1, S_QH2
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_P0, DST_P1, DST_P2, DST_Q0, DST_Q1, DST_Q2,
    DST_DET, DST_UN, DST_VN, DST_TN
  } dst_t;

  typedef struct packed {
    src_t src_a;
    src_t src_b;
    logic neg;
    logic hi;
    logic first;
    logic last;
    dst_t dest;
  } mop_t;

  typedef struct packed {
    logic done;
    dst_t dest;
  } mac_stat_t;

  function automatic mop_t mk(src_t a, src_t b, logic neg, logic hi, logic first, dst_t dest);
    mop_t m;
    m.src_a = a;
    m.src_b = b;
    m.neg   = neg;
    m.hi    = hi;
    m.first = first;
    m.last  = (dest != DST_NONE);
    m.dest  = dest;
    return m;
  endfunction

  // cross products, then the four dot products with split high/low halves
  function automatic mop_t prog(logic [5:0] step);
    mop_t m;
    m = mk(S_D0, S_D0, 1'b0, 1'b0, 1'b1, DST_NONE);
    case (step)
      6'd0:  m = mk(S_D1, S_E22, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd1:  m = mk(S_D2, S_E21, 1'b1, 1'b0, 1'b0, DST_P0);
      6'd2:  m = mk(S_D2, S_E20, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd3:  m = mk(S_D0, S_E22, 1'b1, 1'b0, 1'b0, DST_P1);
      6'd4:  m = mk(S_D0, S_E21, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd5:  m = mk(S_D1, S_E20, 1'b1, 1'b0, 1'b0, DST_P2);
      6'd6:  m = mk(S_T1, S_E12, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd7:  m = mk(S_T2, S_E11, 1'b1, 1'b0, 1'b0, DST_Q0);
      6'd8:  m = mk(S_T2, S_E10, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd9:  m = mk(S_T0, S_E12, 1'b1, 1'b0, 1'b0, DST_Q1);
      6'd10: m = mk(S_T0, S_E11, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd11: m = mk(S_T1, S_E10, 1'b1, 1'b0, 1'b0, DST_Q2);
      6'd12: m = mk(S_E10, S_PL0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd13: m = mk(S_E10, S_PH0, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd14: m = mk(S_E11, S_PL1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd15: m = mk(S_E11, S_PH1, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd16: m = mk(S_E12, S_PL2, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd17: m = mk(S_E12, S_PH2, 1'b0, 1'b1, 1'b0, DST_DET);
      6'd18: m = mk(S_T0, S_PL0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd19: m = mk(S_T0, S_PH0, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd20: m = mk(S_T1, S_PL1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd21: m = mk(S_T1, S_PH1, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd22: m = mk(S_T2, S_PL2, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd23: m = mk(S_T2, S_PH2, 1'b0, 1'b1, 1'b0, DST_UN);
      6'd24: m = mk(S_D0, S_QL0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd25: m = mk(S_D0, S_QH0, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd26: m = mk(S_D1, S_QL1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd27: m = mk(S_D1, S_QH1, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd28: m = mk(S_D2, S_QL2, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd29: m = mk(S_D2, S_QH2, 1'b0, 1'b1, 1'b0, DST_VN);
      6'd30: m = mk(S_E20, S_QL0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd31: m = mk(S_E20, S_QH0, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd32: m = mk(S_E21, S_QL1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd33: m = mk(S_E21, S_QH1, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd34: m = mk(S_E22, S_QL2, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd35: m = mk(S_E22, S_QH2, 1'b0, 1'b1, 1'b0, DST_TN);
      default: m = mk(S_D0, S_D0, 1'b0, 1'b0, 1'b1, DST_NONE);
    endcase
    return m;
  endfunction

endpackage

// File: hdl/ray_triangle_nearest_hit_top.sv
// top level: ray/triangle nearest-hit engine with sequencer and result register
// For each triangle item, 36 passes through the shared 34x34 multiplier build
// the cross and dot products; the multiplier then drains, the determinant is
// normalized and, unless it is zero, the hit is tested; on a hit the
// one-bit-per-cycle divider computes 32 quotient bits for the distance and,
// when the record is replaced, FRAC_BITS+1 bits each for the two barycentrics.
// in_ready is high whenever the engine is idle, so a new item is taken only
// after the last one is through; the result item sits in an output register
// and the engine holds in its final state only when the item flagged last_tri
// finishes while an earlier result still waits.
// Configuration is taken every cycle.
module ray_triangle_nearest_hit_top #(
  parameter int unsigned MAX_TRIANGLES = 65536,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rtnh_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rtnh_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MAC   = 9'b000000010,
    ST_MWAIT = 9'b000000100,
    ST_NORM  = 9'b000001000,
    ST_TEST  = 9'b000010000,
    ST_DIVT  = 9'b000100000,
    ST_DIVU  = 9'b001000000,
    ST_DIVV  = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] T_MIN = 32'h8000_0000;

  state_t state_r, state_nxt;

  logic signed [31:0] cfg_r [8];
  logic signed [32:0] e1_r [3];
  logic signed [32:0] e2_r [3];
  logic signed [32:0] tv_r [3];
  logic signed [rtnh_pkg::CRW-1:0] p_r [3];
  logic signed [rtnh_pkg::CRW-1:0] q_r [3];
  logic signed [rtnh_pkg::ACW-1:0] det_r, un_r, vn_r, tn_r;
  logic        mode_r, last_r, tneg_r;
  logic [5:0]  step_r;

  logic signed [31:0] best_dist_r;
  logic [16:0] best_u_r, best_v_r;
  logic [15:0] best_idx_r, tri_cnt_r;
  logic        any_hit_r;

  logic           out_valid_r;
  rtnh_pkg::out_t out_r;
  rtnh_pkg::out_t res;

  // shared units
  rtnh_pkg::mop_t      mop;
  rtnh_pkg::mac_stat_t mstat;
  logic signed [rtnh_pkg::OPW-1:0] opa, opb;
  logic signed [rtnh_pkg::ACW-1:0] acc;
  logic                        div_start, div_done;
  logic [rtnh_pkg::DVW-1:0]    div_num, div_dvs;
  logic [5:0]                  div_nbits;
  logic [rtnh_pkg::QW-1:0]     quo;

  logic in_acc;
  logic fin_go;
  logic hit;
  logic signed [rtnh_pkg::ACW:0] uv_sum;
  logic signed [31:0] t_val;
  logic [16:0] tri_inc;

  assign in_acc    = in_valid & in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the last item waits only while an earlier result is still held
  assign fin_go = (state_r == ST_FIN) & ~(last_r & out_valid_r & ~out_ready);

  assign mop = rtnh_pkg::prog(step_r);

  function automatic logic signed [rtnh_pkg::OPW-1:0] sel(
    rtnh_pkg::src_t s,
    logic signed [31:0] d0, logic signed [31:0] d1, logic signed [31:0] d2,
    logic signed [32:0] a0, logic signed [32:0] a1, logic signed [32:0] a2,
    logic signed [32:0] b0, logic signed [32:0] b1, logic signed [32:0] b2,
    logic signed [32:0] c0, logic signed [32:0] c1, logic signed [32:0] c2,
    logic signed [rtnh_pkg::CRW-1:0] p0, logic signed [rtnh_pkg::CRW-1:0] p1,
    logic signed [rtnh_pkg::CRW-1:0] p2, logic signed [rtnh_pkg::CRW-1:0] q0,
    logic signed [rtnh_pkg::CRW-1:0] q1, logic signed [rtnh_pkg::CRW-1:0] q2);
    logic signed [rtnh_pkg::OPW-1:0] r;
    r = '0;
    case (s)
      rtnh_pkg::S_D0:  r = rtnh_pkg::OPW'(d0);
      rtnh_pkg::S_D1:  r = rtnh_pkg::OPW'(d1);
      rtnh_pkg::S_D2:  r = rtnh_pkg::OPW'(d2);
      rtnh_pkg::S_E10: r = rtnh_pkg::OPW'(a0);
      rtnh_pkg::S_E11: r = rtnh_pkg::OPW'(a1);
      rtnh_pkg::S_E12: r = rtnh_pkg::OPW'(a2);
      rtnh_pkg::S_E20: r = rtnh_pkg::OPW'(b0);
      rtnh_pkg::S_E21: r = rtnh_pkg::OPW'(b1);
      rtnh_pkg::S_E22: r = rtnh_pkg::OPW'(b2);
      rtnh_pkg::S_T0:  r = rtnh_pkg::OPW'(c0);
      rtnh_pkg::S_T1:  r = rtnh_pkg::OPW'(c1);
      rtnh_pkg::S_T2:  r = rtnh_pkg::OPW'(c2);
      rtnh_pkg::S_PL0: r = {1'b0, p0[32:0]};
      rtnh_pkg::S_PL1: r = {1'b0, p1[32:0]};
      rtnh_pkg::S_PL2: r = {1'b0, p2[32:0]};
      rtnh_pkg::S_PH0: r = p0[66:33];
      rtnh_pkg::S_PH1: r = p1[66:33];
      rtnh_pkg::S_PH2: r = p2[66:33];
      rtnh_pkg::S_QL0: r = {1'b0, q0[32:0]};
      rtnh_pkg::S_QL1: r = {1'b0, q1[32:0]};
      rtnh_pkg::S_QL2: r = {1'b0, q2[32:0]};
      rtnh_pkg::S_QH0: r = q0[66:33];
      rtnh_pkg::S_QH1: r = q1[66:33];
      rtnh_pkg::S_QH2: r = q2[66:33];
      default:         r = '0;
    endcase
    return r;
  endfunction

  assign opa = sel(mop.src_a, cfg_r[3], cfg_r[4], cfg_r[5], e1_r[0], e1_r[1], e1_r[2],
                   e2_r[0], e2_r[1], e2_r[2], tv_r[0], tv_r[1], tv_r[2],
                   p_r[0], p_r[1], p_r[2], q_r[0], q_r[1], q_r[2]);
  assign opb = sel(mop.src_b, cfg_r[3], cfg_r[4], cfg_r[5], e1_r[0], e1_r[1], e1_r[2],
                   e2_r[0], e2_r[1], e2_r[2], tv_r[0], tv_r[1], tv_r[2],
                   p_r[0], p_r[1], p_r[2], q_r[0], q_r[1], q_r[2]);

  rtnh_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (state_r == ST_MAC),
    .op       (mop),
    .a        (opa),
    .b        (opb),
    .stat     (mstat),
    .acc      (acc)
  );

  rtnh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .dvs   (div_dvs),
    .nbits (div_nbits),
    .done  (div_done),
    .quo   (quo)
  );

  // hit test on the sign-normalized sums
  assign uv_sum = (rtnh_pkg::ACW+1)'(un_r) + (rtnh_pkg::ACW+1)'(vn_r);
  assign hit = ~un_r[rtnh_pkg::ACW-1] & (un_r <= det_r) & ~vn_r[rtnh_pkg::ACW-1] &
               (uv_sum <= (rtnh_pkg::ACW+1)'(det_r));

  // saturating signed distance from the quotient magnitude
  always_comb begin
    if (quo[31]) t_val = tneg_r ? T_MIN : T_MAX;
    else if (tneg_r) t_val = -$signed({1'b0, quo[30:0]});
    else t_val = $signed({1'b0, quo[30:0]});
  end

  assign tri_inc = {1'b0, tri_cnt_r} + 17'd1;

  // result item for the mesh that ends with this triangle
  always_comb begin
    res = '0;
    if (mode_r) begin
      res.hit_found = any_hit_r;
    end else if (best_dist_r != T_MAX && best_dist_r > cfg_r[6] &&
                 best_dist_r < cfg_r[7]) begin
      res.hit_found    = 1'b1;
      res.hit_distance = best_dist_r;
      res.bary_u       = best_u_r;
      res.bary_v       = best_v_r;
      res.hit_triangle = best_idx_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = '0;
    div_dvs   = '0;
    div_nbits = '0;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_MAC;
      ST_MAC:   if (step_r == 6'(rtnh_pkg::NSTEP - 1)) state_nxt = ST_MWAIT;
      ST_MWAIT: if (mstat.done && mstat.dest == rtnh_pkg::DST_TN) state_nxt = ST_NORM;
      ST_NORM:  state_nxt = (det_r == '0) ? ST_FIN : ST_TEST;
      ST_TEST: begin
        if (hit) begin
          state_nxt = ST_DIVT;
          div_start = 1'b1;
          div_num   = rtnh_pkg::DVW'(tn_r[rtnh_pkg::ACW-1] ? -tn_r : tn_r) << FRAC_BITS;
          div_dvs   = rtnh_pkg::DVW'(det_r) << rtnh_pkg::TSAT_SHIFT;
          div_nbits = 6'(rtnh_pkg::TSAT_SHIFT + 1);
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIVT: begin
        if (div_done) begin
          if (t_val < best_dist_r) begin
            state_nxt = ST_DIVU;
            div_start = 1'b1;
            div_num   = rtnh_pkg::DVW'(un_r) << FRAC_BITS;
            div_dvs   = rtnh_pkg::DVW'(det_r) << FRAC_BITS;
            div_nbits = 6'(FRAC_BITS + 1);
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_DIVU: begin
        if (div_done) begin
          state_nxt = ST_DIVV;
          div_start = 1'b1;
          div_num   = rtnh_pkg::DVW'(vn_r) << FRAC_BITS;
          div_dvs   = rtnh_pkg::DVW'(det_r) << FRAC_BITS;
          div_nbits = 6'(FRAC_BITS + 1);
        end
      end
      ST_DIVV:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r   <= in_data.mode;
      last_r   <= in_data.last_tri;
      e1_r[0]  <= 33'($signed(in_data.b_x)) - 33'($signed(in_data.a_x));
      e1_r[1]  <= 33'($signed(in_data.b_y)) - 33'($signed(in_data.a_y));
      e1_r[2]  <= 33'($signed(in_data.b_z)) - 33'($signed(in_data.a_z));
      e2_r[0]  <= 33'($signed(in_data.c_x)) - 33'($signed(in_data.a_x));
      e2_r[1]  <= 33'($signed(in_data.c_y)) - 33'($signed(in_data.a_y));
      e2_r[2]  <= 33'($signed(in_data.c_z)) - 33'($signed(in_data.a_z));
      tv_r[0]  <= 33'(cfg_r[0]) - 33'($signed(in_data.a_x));
      tv_r[1]  <= 33'(cfg_r[1]) - 33'($signed(in_data.a_y));
      tv_r[2]  <= 33'(cfg_r[2]) - 33'($signed(in_data.a_z));
    end
    if (mstat.done) begin
      case (mstat.dest)
        rtnh_pkg::DST_P0:  p_r[0] <= acc[rtnh_pkg::CRW-1:0];
        rtnh_pkg::DST_P1:  p_r[1] <= acc[rtnh_pkg::CRW-1:0];
        rtnh_pkg::DST_P2:  p_r[2] <= acc[rtnh_pkg::CRW-1:0];
        rtnh_pkg::DST_Q0:  q_r[0] <= acc[rtnh_pkg::CRW-1:0];
        rtnh_pkg::DST_Q1:  q_r[1] <= acc[rtnh_pkg::CRW-1:0];
        rtnh_pkg::DST_Q2:  q_r[2] <= acc[rtnh_pkg::CRW-1:0];
        rtnh_pkg::DST_DET: det_r  <= acc;
        rtnh_pkg::DST_UN:  un_r   <= acc;
        rtnh_pkg::DST_VN:  vn_r   <= acc;
        rtnh_pkg::DST_TN:  tn_r   <= acc;
        default: ;
      endcase
    end
    // make the determinant positive
    if (state_r == ST_NORM && det_r[rtnh_pkg::ACW-1]) begin
      det_r <= -det_r;
      un_r  <= -un_r;
      vn_r  <= -vn_r;
      tn_r  <= -tn_r;
    end
    if (state_r == ST_TEST) tneg_r <= tn_r[rtnh_pkg::ACW-1];

    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cfg_r[0]    <= '0;
      cfg_r[1]    <= '0;
      cfg_r[2]    <= '0;
      cfg_r[3]    <= '0;
      cfg_r[4]    <= '0;
      cfg_r[5]    <= 32'sd65536;
      cfg_r[6]    <= '0;
      cfg_r[7]    <= T_MAX;
      best_dist_r <= T_MAX;
      best_u_r    <= '0;
      best_v_r    <= '0;
      best_idx_r  <= '0;
      tri_cnt_r   <= '0;
      any_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_index <= rtnh_pkg::REG_DIST_MAX) cfg_r[cfg_index[2:0]] <= cfg_data;
      if (state_r == ST_MAC) step_r <= step_r + 6'd1;
      else step_r <= '0;
      if (state_r == ST_TEST && hit) any_hit_r <= 1'b1;
      if (state_r == ST_DIVT && div_done && t_val < best_dist_r) begin
        best_dist_r <= t_val;
        best_idx_r  <= tri_cnt_r;
      end
      if (state_r == ST_DIVU && div_done) best_u_r <= quo[16:0];
      if (state_r == ST_DIVV && div_done) best_v_r <= quo[16:0];
      if (fin_go && last_r) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (fin_go) begin
        if (last_r) begin
          out_r       <= res;
          best_dist_r <= T_MAX;
          best_u_r    <= '0;
          best_v_r    <= '0;
          best_idx_r  <= '0;
          tri_cnt_r   <= '0;
          any_hit_r   <= 1'b0;
        end else if (32'(tri_inc) >= MAX_TRIANGLES) begin
          tri_cnt_r <= '0;
        end else begin
          tri_cnt_r <= tri_inc[15:0];
        end
      end
    end
  end

endmodule

// File: hdl/rtnh_mac.sv
// shared signed multiplier with a registered product and a wide accumulator
module rtnh_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 op_valid,
  input  rtnh_pkg::mop_t                       op,
  input  logic signed [rtnh_pkg::OPW-1:0]      a,
  input  logic signed [rtnh_pkg::OPW-1:0]      b,
  output rtnh_pkg::mac_stat_t                  stat,
  output logic signed [rtnh_pkg::ACW-1:0]      acc
);

  logic signed [rtnh_pkg::PRW-1:0] prod_r;
  logic                            v1_r;
  rtnh_pkg::mop_t                  op1_r;
  logic signed [rtnh_pkg::ACW-1:0] acc_r, acc_nxt, term;
  rtnh_pkg::mac_stat_t             stat_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    op1_r  <= op;
    acc_r  <= acc_nxt;
    if (!rst_n) begin
      v1_r   <= 1'b0;
      stat_r <= '0;
    end else begin
      v1_r        <= op_valid;
      stat_r.done <= v1_r & op1_r.last;
      stat_r.dest <= op1_r.dest;
    end
  end

  always_comb begin
    term = rtnh_pkg::ACW'(prod_r);
    if (op1_r.hi) term = term <<< 33;
    if (op1_r.neg) term = -term;
    acc_nxt = acc_r;
    if (v1_r) acc_nxt = (op1_r.first ? '0 : acc_r) + term;
  end

  assign acc  = acc_r;
  assign stat = stat_r;

endmodule

// File: hdl/rtnh_div.sv
// restoring divider, one quotient bit per cycle
module rtnh_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rtnh_pkg::DVW-1:0]     num,
  input  logic [rtnh_pkg::DVW-1:0]     dvs,
  input  logic [5:0]                   nbits,
  output logic                         done,
  output logic [rtnh_pkg::QW-1:0]      quo
);

  logic [rtnh_pkg::DVW-1:0] rem_r, dvs_r;
  logic [rtnh_pkg::QW-1:0]  quo_r;
  logic [5:0]               cnt_r;
  logic                     busy_r, done_r, ge;

  assign ge = (rem_r >= dvs_r);

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dvs_r <= dvs;
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dvs_r;
      dvs_r <= dvs_r >> 1;
      quo_r <= {quo_r[rtnh_pkg::QW-2:0], ge};
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: hdl/rtnh_chk.sv
// port-level checker for the ray/triangle engine, bound to the top level
module rtnh_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input rtnh_pkg::out_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // one triangle at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // an idle engine stays ready until an item arrives
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("ready dropped without an input item");

  // a miss carries zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit_found |-> out_data.hit_distance == '0 &&
      out_data.bary_u == '0 && out_data.bary_v == '0 && out_data.hit_triangle == '0)
    else $error("miss result with nonzero fields");

endmodule

bind ray_triangle_nearest_hit_top rtnh_chk u_rtnh_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/ray_triangle_nearest_hit_top_test.sv
// self-checking testbench for the ray/triangle nearest-hit engine
module ray_triangle_nearest_hit_top_test;

  localparam int MAX_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rtnh_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rtnh_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  bit failed = 1'b0;

  ray_triangle_nearest_hit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  class hit_scoreboard;
    logic signed [31:0] ray_reg [8];
    longint best_dist;
    logic [16:0] best_u, best_v;
    logic [15:0] best_tri, tri_num;
    bit any_hit;
    rtnh_pkg::out_t pending_hits[$];

    function void clear_ray();
      best_dist = 64'sd2147483647;
      best_u = '0;
      best_v = '0;
      best_tri = '0;
      tri_num = '0;
      any_hit = 1'b0;
    endfunction

    function void reset_regs();
      foreach (ray_reg[i]) ray_reg[i] = '0;
      ray_reg[rtnh_pkg::REG_DIR_Z] = 32'sd65536;
      ray_reg[rtnh_pkg::REG_DIST_MAX] = 32'sh7fffffff;
      clear_ray();
    endfunction

    function void cross3(input logic signed [127:0] a[3],
                         input logic signed [127:0] b[3],
                         output logic signed [127:0] o[3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function logic signed [127:0] dot3(input logic signed [127:0] a[3],
                                       input logic signed [127:0] b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function void note_triangle(rtnh_pkg::in_t tri_in);
      logic signed [127:0] va[3], vb[3], vc[3], dv[3], e1[3], e2[3], tv[3], p[3], q[3];
      logic signed [127:0] det, un, vn, tn, mag;
      longint t;
      rtnh_pkg::out_t r;
      bit hit;
      va[0] = $signed(tri_in.a_x); va[1] = $signed(tri_in.a_y); va[2] = $signed(tri_in.a_z);
      vb[0] = $signed(tri_in.b_x); vb[1] = $signed(tri_in.b_y); vb[2] = $signed(tri_in.b_z);
      vc[0] = $signed(tri_in.c_x); vc[1] = $signed(tri_in.c_y); vc[2] = $signed(tri_in.c_z);
      for (int k = 0; k < 3; k++) begin
        e1[k] = vb[k] - va[k];
        e2[k] = vc[k] - va[k];
        tv[k] = 128'(ray_reg[k]) - va[k];
        dv[k] = 128'(ray_reg[3 + k]);
      end
      cross3(dv, e2, p);
      cross3(tv, e1, q);
      det = dot3(e1, p);
      un = dot3(tv, p);
      vn = dot3(dv, q);
      tn = dot3(e2, q);
      hit = (det != 0);
      if (det < 0) begin
        det = -det; un = -un; vn = -vn; tn = -tn;
      end
      if (hit && (un < 0 || un > det || vn < 0 || un + vn > det)) hit = 1'b0;
      if (hit) begin
        mag = ((tn < 0 ? -tn : tn) <<< 16) / det;
        if (tn >= 0) t = (mag > 128'sd2147483647) ? 64'sd2147483647 : longint'(mag);
        else t = (mag >= 128'sd2147483648) ? -64'sd2147483648 : -longint'(mag);
        any_hit = 1'b1;
        if (t < best_dist) begin
          best_dist = t;
          best_u = 17'((un <<< 16) / det);
          best_v = 17'((vn <<< 16) / det);
          best_tri = tri_num;
        end
      end
      tri_num = tri_num + 16'd1;
      if (!tri_in.last_tri) return;
      r = '0;
      if (tri_in.mode) r.hit_found = any_hit;
      else if (best_dist != 64'sd2147483647 &&
               best_dist > longint'(ray_reg[rtnh_pkg::REG_DIST_MIN]) &&
               best_dist < longint'(ray_reg[rtnh_pkg::REG_DIST_MAX])) begin
        r.hit_found = 1'b1;
        r.hit_distance = 32'(best_dist);
        r.bary_u = best_u;
        r.bary_v = best_v;
        r.hit_triangle = best_tri;
      end
      pending_hits.push_back(r);
      clear_ray();
    endfunction

    function bit check_result(rtnh_pkg::out_t got);
      rtnh_pkg::out_t exp_r;
      bit ok;
      if (pending_hits.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, got);
        return 1'b0;
      end
      exp_r = pending_hits.pop_front();
      ok = 1'b1;
      if (got.hit_found !== exp_r.hit_found) begin
        $display("%0t: hit_found exp %0d got %0d", $time, exp_r.hit_found, got.hit_found);
        ok = 1'b0;
      end
      if (got.hit_distance !== exp_r.hit_distance) begin
        $display("%0t: hit_distance exp %h got %h", $time, exp_r.hit_distance,
                 got.hit_distance);
        ok = 1'b0;
      end
      if (got.bary_u !== exp_r.bary_u) begin
        $display("%0t: bary_u exp %h got %h", $time, exp_r.bary_u, got.bary_u);
        ok = 1'b0;
      end
      if (got.bary_v !== exp_r.bary_v) begin
        $display("%0t: bary_v exp %h got %h", $time, exp_r.bary_v, got.bary_v);
        ok = 1'b0;
      end
      if (got.hit_triangle !== exp_r.hit_triangle) begin
        $display("%0t: hit_triangle exp %h got %h", $time, exp_r.hit_triangle,
                 got.hit_triangle);
        ok = 1'b0;
      end
      return ok;
    endfunction
  endclass

  hit_scoreboard sb = new();

  // receiver side: random stall, check on every accepted result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready)
      if (!sb.check_result(out_data)) failed <= 1'b1;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (cycles >= MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_triangle(rtnh_pkg::in_t tri_in);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= tri_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_triangle(tri_in);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(rtnh_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.ray_reg[idx] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
    endcase
  endfunction

  // triangle around the ray origin in x and y at a random depth, from slightly behind to in front, vertices jittered
  function automatic rtnh_pkg::in_t aimed_triangle(bit mode, bit last);
    rtnh_pkg::in_t tr;
    logic signed [31:0] ox, oy, oz, z, s;
    ox = sb.ray_reg[rtnh_pkg::REG_ORIGIN_X];
    oy = sb.ray_reg[rtnh_pkg::REG_ORIGIN_Y];
    oz = sb.ray_reg[rtnh_pkg::REG_ORIGIN_Z];
    z = oz + $signed($urandom_range(20 * 65536)) - 2 * 65536;
    s = $urandom_range(4 * 65536, 65536);
    tr.mode = mode;
    tr.last_tri = last;
    tr.a_x = ox - s + $signed($urandom_range(s)); tr.a_y = oy - s; tr.a_z = z;
    tr.b_x = ox + s; tr.b_y = oy - s + $signed($urandom_range(s));
    tr.b_z = z + $signed($urandom_range(65536)) - 32768;
    tr.c_x = ox - s; tr.c_y = oy + s; tr.c_z = z;
    return tr;
  endfunction

  function automatic rtnh_pkg::in_t noise_triangle(bit mode, bit last);
    rtnh_pkg::in_t tr;
    tr = {1'b0, rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0};
    tr.mode = mode;
    tr.last_tri = last;
    return tr;
  endfunction

  task automatic random_ray_setup(bit axis_ray);
    write_reg(rtnh_pkg::REG_ORIGIN_X, axis_ray ? 32'd0 : rand_coord());
    write_reg(rtnh_pkg::REG_ORIGIN_Y, axis_ray ? 32'd0 : rand_coord());
    write_reg(rtnh_pkg::REG_ORIGIN_Z,
              axis_ray ? 32'd0 : 32'($signed($urandom_range(65536 * 4)) - 65536 * 2));
    write_reg(rtnh_pkg::REG_DIR_X,
              axis_ray ? 32'd0 : 32'($signed($urandom_range(8192)) - 4096));
    write_reg(rtnh_pkg::REG_DIR_Y,
              axis_ray ? 32'd0 : 32'($signed($urandom_range(8192)) - 4096));
    write_reg(rtnh_pkg::REG_DIR_Z,
              $urandom_range(3) == 0 ? rand_coord() : 32'($urandom_range(65536 * 2, 1)));
    write_reg(rtnh_pkg::REG_DIST_MIN, $urandom_range(3) == 0 ? 32'h80000000 :
              32'($signed($urandom_range(65536 * 2)) - 65536));
    write_reg(rtnh_pkg::REG_DIST_MAX, $urandom_range(3) == 0 ? 32'h7fffffff :
              32'($urandom_range(65536 * 16)));
  endtask

  initial begin
    rtnh_pkg::in_t tr;
    int n_tri;
    sb.reset_regs();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default ray along +z
    tr = '0;
    tr.a_x = -32'sd65536; tr.a_y = -32'sd65536; tr.a_z = 32'sd131072;
    tr.b_x = 32'sd65536;  tr.b_y = -32'sd65536; tr.b_z = 32'sd131072;
    tr.c_x = -32'sd65536; tr.c_y = 32'sd65536;  tr.c_z = 32'sd131072;
    tr.last_tri = 1'b1;
    send_triangle(tr);                                // simple closest hit
    tr.mode = 1'b1;
    send_triangle(tr);                                // shadow hit
    tr.mode = 1'b0; tr.last_tri = 1'b0;
    send_triangle(tr);
    tr.a_z = -32'sd131072; tr.b_z = -32'sd131072; tr.c_z = -32'sd131072;
    send_triangle(tr);                                // behind origin masks the far one
    tr.last_tri = 1'b1;
    tr.a_z = 32'sd65536; tr.b_z = 32'sd65536; tr.c_z = 32'sd65536;
    send_triangle(tr);
    tr = '0; tr.last_tri = 1'b1;                      // degenerate triangle
    send_triangle(tr);
    tr = '1; send_triangle(tr);
    tr = {1'b0, {3{32'h7fffffff}}, {3{32'h80000000}}, {3{32'h7fffffff}}, 1'b1};
    send_triangle(tr);
    tr.mode = 1'b1; send_triangle(tr);
    wait_drained();
    // far hit that saturates the distance
    write_reg(rtnh_pkg::REG_DIR_Z, 32'd1);
    tr = '0;
    tr.a_x = 32'h80000000; tr.a_y = 32'h80000000; tr.a_z = 32'h7fff0000;
    tr.b_x = 32'h7fffffff; tr.b_y = 32'h80000000; tr.b_z = 32'h7fff0000;
    tr.c_x = 32'h80000000; tr.c_y = 32'h7fffffff; tr.c_z = 32'h7fff0000;
    tr.last_tri = 1'b1;
    send_triangle(tr);
    tr.mode = 1'b1; send_triangle(tr);
    wait_drained();
    write_reg(rtnh_pkg::REG_DIR_Z, 32'd0);            // zero direction: parallel
    tr.mode = 1'b0; send_triangle(tr);
    wait_drained();
    write_reg(rtnh_pkg::REG_DIR_Z, 32'sd65536);
    write_reg(rtnh_pkg::REG_DIST_MIN, 32'sd65536 * 3); // window rejects hits nearer than three units
    tr = aimed_triangle(1'b0, 1'b1);
    send_triangle(tr);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 83 : 0;
      recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 6 : 0;
      for (int ray = 0; ray < 35; ray++) begin
        random_ray_setup(ray % 3 == 0);
        for (int mesh = 0; mesh < 3; mesh++) begin
          n_tri = $urandom_range(8, 1);
          for (int i = 0; i < n_tri; i++) begin
            if ($urandom_range(9) < 7) tr = aimed_triangle($urandom_range(1), i == n_tri - 1);
            else tr = noise_triangle($urandom_range(1), i == n_tri - 1);
            send_triangle(tr);
          end
          if ($urandom_range(15) == 0) wait_drained();
        end
        wait_drained();
      end
    end

    wait_drained();
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/rtnh_pkg.sv
hdl/rtnh_mac.sv
hdl/rtnh_div.sv
hdl/ray_triangle_nearest_hit_top.sv
hdl/rtnh_chk.sv
sim/ray_triangle_nearest_hit_top_test.sv
